@@ hdl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg - polygon point containment shared definitions
// Request codes, default sizes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ppc_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_BITS   = 16;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

	typedef struct packed {
		logic clear;
		logic append;
		logic start;
		logic rd_en;
		logic tri_en;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
		logic ge3;
	} sts_t;

endpackage

@@ hdl/ppc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppc_ctrl - request sequencer
// Takes requests, walks the fan triangles of a test one vertex read per
// cycle, waits for the datapath to drain and hands the result over.
// ----------------------------------------------------------------------------
module ppc_ctrl #(
	parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ppc_pkg::OP_W-1:0]            op,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   count,
	input  ppc_pkg::sts_t                       sts,
	output ppc_pkg::cmd_t                       cmd,
	output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] k_q;
	logic          accept;
	logic          walk_end;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign walk_end = (CNT_W'(k_q) == (count - CNT_W'(1)));
	assign rd_addr  = k_q;

	always_comb begin
		cmd          = '0;
		cmd.clear    = accept && (op == ppc_pkg::OP_CLEAR);
		cmd.append   = accept && (op == ppc_pkg::OP_APPEND);
		cmd.start    = accept && (op == ppc_pkg::OP_TEST);
		cmd.rd_en    = (state_q == ST_WALK);
		cmd.tri_en   = (state_q == ST_WALK) && (k_q != AW'(1));
		cmd.load_out = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						k_q     <= AW'(1);
						state_q <= sts.ge3 ? ST_WALK : ST_DRAIN;
					end
				end
				ST_WALK: begin
					k_q <= k_q + AW'(1);
					if (walk_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// pipeline is empty whenever a new request can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.busy)
		else $error("datapath busy while idle");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (CNT_W'(rd_addr) < count))
		else $error("vertex read beyond stored count");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.busy)
		else $error("result loaded before pipeline drained");

endmodule

@@ hdl/ppc_datapath.sv @@
// ----------------------------------------------------------------------------
// ppc_datapath - vertex store and area test pipeline
// Holds the polygon, evaluates one fan triangle per cycle through the
// area pipeline (stages s1 to s4) and keeps the result register.
// ----------------------------------------------------------------------------
module ppc_datapath #(
	parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = ppc_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppc_pkg::cmd_t                       cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
	output ppc_pkg::sts_t                       sts,
	output logic [$clog2(MAX_VERTICES+1)-1:0]   count,
	input  logic signed [COORD_BITS-1:0]        x,
	input  logic signed [COORD_BITS-1:0]        y,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                point_inside,
	output logic                                any_inside,
	output logic                                run_end,
	output logic                                vertices_dropped
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int C     = COORD_BITS;
	localparam int D_W   = C + 1;
	localparam int P_W   = 2 * C + 2;
	localparam int T_W   = 2 * C + 3;
	localparam int S_W   = 2 * C + 5;

	logic signed [C-1:0] mem_x [MAX_VERTICES];
	logic signed [C-1:0] mem_y [MAX_VERTICES];

	logic [CNT_W-1:0]    cnt_q;
	logic                drop_q;
	logic                run_hit_q;
	logic                hit_q;
	logic signed [C-1:0] v0x_q, v0y_q, px_q, py_q;
	logic signed [C-1:0] rdx_q, rdy_q, prevx_q, prevy_q;
	logic                last_q;
	logic                rd_vld_q, tri_q;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [D_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [P_W-1:0] mab_s2, mba_s2, mbc_s2, mcb_s2, mca_s2, mac_s2;
	logic signed [T_W-1:0] t1_s3, t2_s3, t3_s3;
	logic [T_W-1:0]        a1_s4, a2_s4, a3_s4;
	logic signed [S_W-1:0] tsum_s4;

	logic [S_W-1:0] abs_sum;
	logic [S_W-1:0] tsum_abs;
	logic           tri_hit;
	logic           any_now;

	logic out_valid_q;
	logic point_inside_q, any_inside_q, run_end_q, dropped_q;

	assign count   = cnt_q;
	assign sts.busy     = rd_vld_q || v_s1 || v_s2 || v_s3 || v_s4;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.ge3      = (cnt_q >= CNT_W'(3));

	// vertex store
	always_ff @(posedge clk) begin
		if (cmd.append && (cnt_q < CNT_W'(MAX_VERTICES))) begin
			mem_x[cnt_q[AW-1:0]] <= x;
			mem_y[cnt_q[AW-1:0]] <= y;
		end
		if (cmd.rd_en) begin
			rdx_q <= mem_x[rd_addr];
			rdy_q <= mem_y[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			run_hit_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cnt_q     <= '0;
				drop_q    <= 1'b0;
				run_hit_q <= 1'b0;
			end else if (cmd.append) begin
				if (cnt_q < CNT_W'(MAX_VERTICES)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end else if (cmd.load_out) begin
				run_hit_q <= last_q ? 1'b0 : any_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && (cnt_q == '0)) begin
			v0x_q <= x;
			v0y_q <= y;
		end
		if (cmd.start) begin
			px_q   <= x;
			py_q   <= y;
			last_q <= last_point;
		end
		if (rd_vld_q) begin
			prevx_q <= rdx_q;
			prevy_q <= rdy_q;
		end
	end

	// area pipeline: a = v0, b = previous vertex, c = vertex just read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
			tri_q    <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			rd_vld_q <= cmd.rd_en;
			tri_q    <= cmd.tri_en;
			v_s1     <= rd_vld_q && tri_q;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= D_W'(v0x_q) - D_W'(px_q);
		ay_s1 <= D_W'(v0y_q) - D_W'(py_q);
		bx_s1 <= D_W'(prevx_q) - D_W'(px_q);
		by_s1 <= D_W'(prevy_q) - D_W'(py_q);
		cx_s1 <= D_W'(rdx_q) - D_W'(px_q);
		cy_s1 <= D_W'(rdy_q) - D_W'(py_q);

		mab_s2 <= P_W'(ax_s1) * P_W'(by_s1);
		mba_s2 <= P_W'(bx_s1) * P_W'(ay_s1);
		mbc_s2 <= P_W'(bx_s1) * P_W'(cy_s1);
		mcb_s2 <= P_W'(cx_s1) * P_W'(by_s1);
		mca_s2 <= P_W'(cx_s1) * P_W'(ay_s1);
		mac_s2 <= P_W'(ax_s1) * P_W'(cy_s1);

		t1_s3 <= T_W'(mab_s2) - T_W'(mba_s2);
		t2_s3 <= T_W'(mbc_s2) - T_W'(mcb_s2);
		t3_s3 <= T_W'(mca_s2) - T_W'(mac_s2);

		a1_s4   <= t1_s3[T_W-1] ? T_W'(-t1_s3) : T_W'(t1_s3);
		a2_s4   <= t2_s3[T_W-1] ? T_W'(-t2_s3) : T_W'(t2_s3);
		a3_s4   <= t3_s3[T_W-1] ? T_W'(-t3_s3) : T_W'(t3_s3);
		tsum_s4 <= S_W'(t1_s3) + S_W'(t2_s3) + S_W'(t3_s3);
	end

	// signed subareas always add up to the signed whole area
	assign abs_sum  = S_W'(a1_s4) + S_W'(a2_s4) + S_W'(a3_s4);
	assign tsum_abs = tsum_s4[S_W-1] ? S_W'(-tsum_s4) : S_W'(tsum_s4);
	assign tri_hit  = (abs_sum == tsum_abs);
	assign any_now  = run_hit_q || hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start) begin
			hit_q <= 1'b0;
		end else if (v_s4 && tri_hit) begin
			hit_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			point_inside_q <= hit_q;
			any_inside_q   <= any_now;
			run_end_q      <= last_q;
			dropped_q      <= drop_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign point_inside     = point_inside_q;
	assign any_inside       = any_inside_q;
	assign run_end          = run_end_q;
	assign vertices_dropped = dropped_q;

endmodule

@@ hdl/polygon_point_containment_core.sv @@
// ----------------------------------------------------------------------------
// polygon_point_containment_core - point in polygon by fan triangle areas
// Holds one polygon and tests query points against its fan triangles.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): op 0 clears the polygon, op 1 appends
// vertex (x,y), op 2 tests point (x,y); last_point closes a query run.
// op 3 is taken and ignored. Clear and append give no result; appends past
// MAX_VERTICES are dropped and flagged sticky.
// Output channel (out_valid/out_stall): one result per test carrying
// point_inside, the run's any_inside, run_end and vertices_dropped.
// During a test of a polygon of three or more vertices the input stays
// stalled while the vertices after the first are read one per cycle from
// the vertex store, followed by the area pipeline (stages s1 to s4) and
// the result hand-over; with fewer than three vertices the walk is skipped.
// A new test is taken only once the previous one has been handed over.
// A result waits in the output register while the receiver stalls; clears
// and appends are still taken meanwhile, but the next test finishes only
// once the register is free.
// Reset empties the polygon and clears the run and drop flags; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_point_containment_core #(
	parameter int MAX_VERTICES = ppc_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = ppc_pkg::DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ppc_pkg::OP_W-1:0]      op,
	input  logic signed [COORD_BITS-1:0]  x,
	input  logic signed [COORD_BITS-1:0]  y,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          point_inside,
	output logic                          any_inside,
	output logic                          run_end,
	output logic                          vertices_dropped
);

	ppc_pkg::cmd_t                       cmd;
	ppc_pkg::sts_t                       sts;
	logic [$clog2(MAX_VERTICES)-1:0]     rd_addr;
	logic [$clog2(MAX_VERTICES+1)-1:0]   count;

	ppc_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.count    (count),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	ppc_datapath #(
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.rd_addr          (rd_addr),
		.sts              (sts),
		.count            (count),
		.x                (x),
		.y                (y),
		.last_point       (last_point),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.point_inside     (point_inside),
		.any_inside       (any_inside),
		.run_end          (run_end),
		.vertices_dropped (vertices_dropped)
	);

endmodule
